### src/ofrm_pkg.sv
// Shared widths, operation codes and record types of the overwrite FIFO with running mean.
package ofrm_pkg;

   // Field widths fixed by the transaction formats
   localparam int unsigned FUNC_W   = 1;
   localparam int unsigned ID_W     = 12;
   localparam int unsigned HEIGHT_W = 9;
   localparam int unsigned CAP_W    = 4;

   // Width of the divider step counter; it must hold HEIGHT_W
   localparam int unsigned STEP_W = 4;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 1'b1;

   // One stored record
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [HEIGHT_W-1:0] height;
   } record_type;

   // One result transaction
   typedef struct packed {
      logic [HEIGHT_W-1:0] mean_height;
      logic [ID_W-1:0]     out_id;
      logic                out_id_valid;
      logic                empty_error;
   } result_type;

endpackage

### src/ofrm_if.sv
// Valid/ready channel interfaces for requests, responses and the capacity register.

interface ofrm_req_if;
   logic                                valid;
   logic                                ready;
   logic [ofrm_pkg::FUNC_W-1:0]         func;
   logic [ofrm_pkg::ID_W-1:0]           item_id;
   logic [ofrm_pkg::HEIGHT_W-1:0]       item_height;

   modport source (output valid, func, item_id, item_height, input ready);
   modport sink   (input valid, func, item_id, item_height, output ready);
endinterface

interface ofrm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ofrm_pkg::HEIGHT_W-1:0]       mean_height;
   logic [ofrm_pkg::ID_W-1:0]           out_id;
   logic                                out_id_valid;
   logic                                empty_error;

   modport source (output valid, mean_height, out_id, out_id_valid, empty_error, input ready);
   modport sink   (input valid, mean_height, out_id, out_id_valid, empty_error, output ready);
endinterface

interface ofrm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ofrm_pkg::CAP_W-1:0]          capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

### src/ofrm_div.sv
// Iterative restoring divider giving a rounded mean, one quotient bit per cycle.
module ofrm_div #(
   parameter int unsigned CNT_W = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [ofrm_pkg::HEIGHT_W+CNT_W-1:0]   dividend,
   input  logic [CNT_W-1:0]                      divisor,
   output logic                                  done,
   output logic [ofrm_pkg::HEIGHT_W-1:0]         quotient
);

   localparam int unsigned SUM_W = ofrm_pkg::HEIGHT_W + CNT_W;

   logic                            run_ff;
   logic                            done_ff;
   logic [ofrm_pkg::STEP_W-1:0]     step_ff;
   logic [SUM_W-1:0]                rem_ff;
   logic [SUM_W-1:0]                dsh_ff;
   logic [CNT_W-1:0]                div_ff;
   logic [ofrm_pkg::HEIGHT_W-1:0]   q_ff;

   logic                            fits;
   logic [SUM_W:0]                  twice_rem;
   logic [SUM_W:0]                  div_ext;
   logic                            round_up;

   // Trial subtraction and the ties-to-even rounding decision
   always_comb begin
      fits      = rem_ff >= dsh_ff;
      twice_rem = {rem_ff, 1'b0};
      div_ext   = (SUM_W + 1)'(div_ff);
      round_up  = (twice_rem > div_ext) || ((twice_rem == div_ext) && q_ff[0]);
   end

   // Sequencing: HEIGHT_W quotient steps, then one rounding step
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= ofrm_pkg::STEP_W'(ofrm_pkg::HEIGHT_W);
      end else if (run_ff && (step_ff == '0)) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b1;
      end else begin
         done_ff <= 1'b0;
         if (run_ff) begin
            step_ff <= step_ff - 1'b1;
         end
      end
   end

   // Datapath: the divisor is aligned to the top quotient bit and walks right
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsh_ff <= SUM_W'({divisor, (ofrm_pkg::HEIGHT_W - 1)'(0)});
         div_ff <= divisor;
         q_ff   <= '0;
      end else if (run_ff && (step_ff != '0)) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         q_ff   <= {q_ff[ofrm_pkg::HEIGHT_W-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
      end else if (run_ff) begin
         q_ff <= q_ff + ofrm_pkg::HEIGHT_W'(round_up);
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

### src/overwrite_fifo_running_mean_core.sv
// Overwrite-oldest record FIFO that reports evicted ids and the rounded mean height.
//
//  Channel    Direction  Handshake      Carries
//  req_chan   in         valid/ready    func, item_id, item_height
//  rsp_chan   out        valid/ready    mean_height, out_id, out_id_valid, empty_error
//  csr_chan   in         valid/ready    capacity (ready whenever reset is low)
//
// An insert passes from acceptance through the update state, the nine quotient steps and
// one rounding step of the divider and the done state to a result in the output register.
// A remove passes through the update and done states only. One transaction is worked on at a time.
// Reset is synchronous and clears the control state; the record memory is not cleared.
// A stalled response holds in the output register while the next request is accepted.
module overwrite_fifo_running_mean_core #(
   parameter int unsigned MAX_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   ofrm_req_if.sink    req_chan,
   ofrm_rsp_if.source  rsp_chan,
   ofrm_csr_if.sink    csr_chan
);

   localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int unsigned SUM_W = ofrm_pkg::HEIGHT_W + CNT_W;
   localparam int unsigned CMP_W = (CNT_W > ofrm_pkg::CAP_W) ? CNT_W : ofrm_pkg::CAP_W;

   // Sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_UPDATE = 2'd1;
   localparam logic [1:0] S_DIVIDE = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [ofrm_pkg::CAP_W-1:0]    cap_ff;
   logic [ofrm_pkg::FUNC_W-1:0]   op_func_ff;
   ofrm_pkg::record_type          op_rec_ff;
   ofrm_pkg::record_type          rd_rec_ff;
   ofrm_pkg::result_type          res_ff, res_in;
   ofrm_pkg::result_type          rsp_ff;
   logic                          rsp_valid_ff;

   ofrm_pkg::record_type          mem [MAX_DEPTH];

   logic                          req_fire;
   logic                          rsp_free;
   logic                          is_insert;
   logic                          is_remove;
   logic [CMP_W-1:0]              cap_ext;
   logic [CMP_W-1:0]              max_ext;
   logic [CMP_W-1:0]              cap_eff;
   logic                          full;
   logic                          count_zero;
   logic                          pop;
   logic [CNT_W:0]                slot_raw;
   logic [IDX_W-1:0]              slot;
   logic [IDX_W-1:0]              head_step;
   logic                          div_start;
   logic                          div_done;
   logic [ofrm_pkg::HEIGHT_W-1:0] div_quot;

   // Handshakes; nothing is taken while reset is held
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign req_chan.ready   = (state_ff == S_IDLE) && !reset;
   assign rsp_free         = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready   = !reset;

   // Queue decisions for the held operation
   always_comb begin
      is_insert  = (op_func_ff == ofrm_pkg::FUNC_INSERT);
      is_remove  = (op_func_ff == ofrm_pkg::FUNC_REMOVE);
      cap_ext    = CMP_W'(cap_ff);
      max_ext    = CMP_W'(MAX_DEPTH);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > max_ext) begin
         cap_eff = max_ext;
      end else begin
         cap_eff = cap_ext;
      end
      full       = CMP_W'(count_ff) >= cap_eff;
      count_zero = (count_ff == '0);
      pop        = !count_zero && ((is_insert && full) || is_remove);
      // The tail slot is head plus count, wrapped once
      slot_raw   = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
      if (slot_raw >= (CNT_W + 1)'(MAX_DEPTH)) begin
         slot_raw = slot_raw - (CNT_W + 1)'(MAX_DEPTH);
      end
      slot       = slot_raw[IDX_W-1:0];
      head_step  = (head_ff == IDX_W'(MAX_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   end

   // Next state of the sequencer and the queue bookkeeping
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (pop) begin
               head_in = head_step;
            end
            count_in = count_ff - CNT_W'(pop) + CNT_W'(is_insert);
            sum_in   = sum_ff
                     + (is_insert ? SUM_W'(op_rec_ff.height) : '0)
                     - (pop ? SUM_W'(rd_rec_ff.height) : '0);
            res_in.mean_height  = '0;
            res_in.out_id       = pop ? rd_rec_ff.id : '0;
            res_in.out_id_valid = pop;
            res_in.empty_error  = is_remove && count_zero;
            if (is_insert) begin
               div_start = 1'b1;
               state_in  = S_DIVIDE;
            end else begin
               state_in  = S_DONE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               res_in.mean_height = div_quot;
               state_in           = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         cap_ff       <= ofrm_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         if (csr_chan.valid && csr_chan.ready) begin
            cap_ff <= csr_chan.capacity;
         end
         if ((state_ff == S_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: the accepted transaction, the work result and the output stage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_func_ff       <= req_chan.func;
         op_rec_ff.id     <= req_chan.item_id;
         op_rec_ff.height <= req_chan.item_height;
      end
      res_ff <= res_in;
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_ff <= res_ff;
      end
   end

   // Record memory: the oldest record is read every cycle, the tail written on insert
   always_ff @(posedge clock) begin
      rd_rec_ff <= mem[head_ff];
      if ((state_ff == S_UPDATE) && is_insert) begin
         mem[slot] <= op_rec_ff;
      end
   end

   // Divider for the rounded mean
   ofrm_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Response port
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.mean_height  = rsp_ff.mean_height;
   assign rsp_chan.out_id       = rsp_ff.out_id;
   assign rsp_chan.out_id_valid = rsp_ff.out_id_valid;
   assign rsp_chan.empty_error  = rsp_ff.empty_error;

endmodule

### src/ofrm_checker.sv
// Port-level checks of the overwrite FIFO core and their attachment to it.
module ofrm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ofrm_pkg::HEIGHT_W-1:0]   rsp_mean_height,
   input logic [ofrm_pkg::ID_W-1:0]       rsp_out_id,
   input logic                            rsp_out_id_valid,
   input logic                            rsp_empty_error
);

   // A request is worked on alone: the block is busy in the cycle after it is taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a transaction is still in work");

   // An empty-queue remove reports nothing else.
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_error) |-> (!rsp_out_id_valid && (rsp_mean_height == '0)))
      else $error("empty error with an id or a mean");

   // Without a removed or evicted record the id field is zero.
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_id_valid) |-> (rsp_out_id == '0))
      else $error("id shown without a removed record");

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response withdrawn while stalled");

endmodule

bind overwrite_fifo_running_mean_core ofrm_checker u_ofrm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_mean_height  (rsp_chan.mean_height),
   .rsp_out_id       (rsp_chan.out_id),
   .rsp_out_id_valid (rsp_chan.out_id_valid),
   .rsp_empty_error  (rsp_chan.empty_error)
);
